// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned PhaseW = 16;

  // command codes carried by func
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;

  // waveform steps
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_S_SDAHI = 4'd1;
  localparam logic [3:0] PH_S_SCLHI = 4'd2;
  localparam logic [3:0] PH_S_SDALO = 4'd3;
  localparam logic [3:0] PH_S_SCLLO = 4'd4;
  localparam logic [3:0] PH_P_SDALO = 4'd5;
  localparam logic [3:0] PH_P_SCLHI = 4'd6;
  localparam logic [3:0] PH_P_SDAHI = 4'd7;
  localparam logic [3:0] PH_B_SET   = 4'd8;
  localparam logic [3:0] PH_B_HIGH  = 4'd9;
  localparam logic [3:0] PH_B_LOW   = 4'd10;
  localparam logic [3:0] PH_A_REL   = 4'd11;
  localparam logic [3:0] PH_A_HIGH  = 4'd12;
  localparam logic [3:0] PH_END_LOW = 4'd13;
  localparam logic [3:0] PH_R_LOW   = 4'd14;
  localparam logic [3:0] PH_R_HIGH  = 4'd15;

  // configuration register word index
  localparam logic REG_PHASE_TICKS = 1'b0;

  localparam logic [PhaseW-1:0] PHASE_TICKS_RESET = 16'd5;
  localparam int unsigned       BITS_PER_BYTE     = 8;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C bus master advanced by one tick per item; start, stop, byte write,
// byte read and ack bit commands, each waveform step held phase_ticks ticks.
// ----------------------------------------------------------------------------
//  channel   ports                          moves
//  in        in_valid/in_ready/in_data      one tick, optional command
//  out       out_valid/out_ready/out_data   line levels and status per tick
//  cfg       psel/penable/pwrite/paddr/...  phase_ticks at word 0
//
//  one item per clock while out_ready is high: the step logic runs between
//  the state registers and the result register with no stage in between.
//  the result register is reloaded in the same cycle it is taken, so items
//  flow back to back while out_ready stays high.
//  a stall on out holds the result and lowers in_ready; nothing is dropped.
//  reset (rst_n low, synchronous) releases both lines and idles the engine;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import i2cm_pkg::*;

  logic [PhaseW-1:0] phase_ticks_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [PhaseW-1:0] wait_r, wait_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic              done_nxt;
  logic              enter;
  logic [3:0]        enter_ph;
  logic [3:0]        bit_inc;
  logic [PhaseW-1:0] wait_load;
  logic              in_acc;
  logic              out_valid_r;
  out_item_t         out_data_r;

  assign pready  = 1'b1;
  assign prdata  = {{(32-PhaseW){1'b0}}, phase_ticks_r};
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // zero ticks behaves like one
  assign wait_load = (phase_ticks_r == '0) ? '0 : phase_ticks_r - 1'b1;
  assign bit_inc   = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    rx_nxt      = rx_r;
    cmd_nxt     = cmd_r;
    done_nxt    = 1'b0;
    enter       = 1'b0;
    enter_ph    = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      if (in_data.func >= CMD_START && in_data.func <= CMD_ACK) begin
        cmd_nxt     = in_data.func;
        bit_cnt_nxt = '0;
        enter       = 1'b1;
        case (in_data.func)
          CMD_START: enter_ph = PH_S_SDAHI;
          CMD_STOP:  enter_ph = PH_P_SDALO;
          CMD_WRITE: begin
            shift_nxt = in_data.tx_byte;
            enter_ph  = PH_B_SET;
          end
          CMD_READ: begin
            shift_nxt = '0;
            enter_ph  = PH_R_LOW;
          end
          default: begin
            // ack bit rides the write path as a one-bit byte
            shift_nxt = {in_data.ack_bit, 7'b0};
            enter_ph  = PH_B_SET;
          end
        endcase
      end
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - 1'b1;
    end else begin
      enter = 1'b1;
      unique case (phase_r)
        PH_S_SDAHI: enter_ph = PH_S_SCLHI;
        PH_S_SCLHI: enter_ph = PH_S_SDALO;
        PH_S_SDALO: enter_ph = PH_S_SCLLO;
        PH_P_SDALO: enter_ph = PH_P_SCLHI;
        PH_P_SCLHI: enter_ph = PH_P_SDAHI;
        PH_B_SET:   enter_ph = PH_B_HIGH;
        PH_B_HIGH:  enter_ph = PH_B_LOW;
        PH_B_LOW: begin
          if (cmd_r == CMD_ACK) begin
            enter = 1'b0;
            done_nxt = 1'b1;
          end else begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            enter_ph    = (bit_inc < 4'(BITS_PER_BYTE)) ? PH_B_SET : PH_A_REL;
          end
        end
        PH_A_REL:   enter_ph = PH_A_HIGH;
        PH_A_HIGH: begin
          ack_nxt  = !in_data.sda_in;
          enter_ph = PH_END_LOW;
        end
        PH_END_LOW: begin
          if (cmd_r == CMD_READ) begin
            rx_nxt = shift_r;
          end
          enter    = 1'b0;
          done_nxt = 1'b1;
        end
        PH_R_LOW:   enter_ph = PH_R_HIGH;
        PH_R_HIGH: begin
          shift_nxt   = {shift_r[6:0], in_data.sda_in};
          bit_cnt_nxt = bit_inc;
          enter_ph    = (bit_inc < 4'(BITS_PER_BYTE)) ? PH_R_LOW : PH_END_LOW;
        end
        default: begin
          // the last step of a start or a stop ends the command
          enter    = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
      if (done_nxt) begin
        phase_nxt = PH_IDLE;
        wait_nxt  = '0;
      end
    end

    if (enter) begin
      phase_nxt = enter_ph;
      wait_nxt  = wait_load;
      unique case (enter_ph) inside
        PH_S_SDAHI, PH_P_SDAHI, PH_A_REL: sda_nxt = 1'b1;
        PH_S_SDALO, PH_P_SDALO:           sda_nxt = 1'b0;
        PH_B_SET:                         sda_nxt = shift_nxt[7];
        PH_S_SCLHI, PH_P_SCLHI, PH_B_HIGH, PH_A_HIGH, PH_R_HIGH: scl_nxt = 1'b1;
        PH_S_SCLLO, PH_B_LOW, PH_END_LOW: scl_nxt = 1'b0;
        PH_R_LOW: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      wait_r        <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      rx_r          <= '0;
      cmd_r         <= CMD_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_PHASE_TICKS) begin
        phase_ticks_r <= pwdata[PhaseW-1:0];
      end
      if (in_acc) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        wait_r    <= wait_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        ack_r     <= ack_nxt;
        rx_r      <= rx_nxt;
        cmd_r     <= cmd_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.scl      <= scl_nxt;
      out_data_r.sda_out  <= sda_nxt;
      out_data_r.busy_res <= (phase_nxt != PH_IDLE);
      out_data_r.done_res <= done_nxt;
      out_data_r.rx_byte  <= rx_nxt;
      out_data_r.ack_seen <= ack_nxt;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE && in_data.func == CMD_START
    |=> phase_r == PH_S_SDAHI && sda_r)
    else $error("start did not enter its first step");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'(BITS_PER_BYTE))
    else $error("bit counter ran past a byte");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r != PH_IDLE && wait_r != '0 |=> phase_r == $past(phase_r))
    else $error("step left before its ticks ran out");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master byte engine. Ticks are driven
// through the in channel with random gaps, results are taken with random
// stalls and compared field by field against a cycle model of the bus
// waveform. phase_ticks is changed over the APB port between phases of
// the run while the engine is idle, including zero, one and the maximum.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // func codes with no command behind them
  localparam logic [2:0] FUNC_RSVD_A = 3'd6;
  localparam logic [2:0] FUNC_RSVD_B = 3'd7;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // bus waveform model: configuration copy and engine state
  logic [15:0] tick_len  = PHASE_TICKS_RESET;
  logic [3:0]  step_q    = PH_IDLE;
  logic [3:0]  nbits     = '0;
  logic [7:0]  shreg     = '0;
  logic [15:0] hold_left = '0;
  logic        scl_q     = 1'b1;
  logic        sda_q     = 1'b1;
  logic        ack_q     = 1'b0;
  logic [7:0]  rx_q      = '0;
  logic [2:0]  cmd_q     = CMD_NONE;

  in_item_t  tick_items[$];
  out_item_t line_expect[$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        errors = 0;
  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;
  logic      calm = 1'b0;
  int        in_gap = 0;
  int        out_hold = 0;

  function automatic void enter_step(logic [3:0] s);
    step_q = s;
    // zero phase_ticks still holds each step for one tick
    hold_left = (tick_len == 16'd0) ? 16'd0 : tick_len - 16'd1;
    case (s) inside
      PH_S_SDAHI, PH_P_SDAHI, PH_A_REL: sda_q = 1'b1;
      PH_S_SDALO, PH_P_SDALO: sda_q = 1'b0;
      PH_S_SCLHI, PH_P_SCLHI, PH_B_HIGH, PH_A_HIGH, PH_R_HIGH: scl_q = 1'b1;
      PH_S_SCLLO, PH_B_LOW, PH_END_LOW: scl_q = 1'b0;
      PH_B_SET: sda_q = shreg[7];
      PH_R_LOW: begin
        sda_q = 1'b1;
        scl_q = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t bus_tick(in_item_t it);
    out_item_t r;
    logic      fin;
    fin = 1'b0;
    if (step_q == PH_IDLE) begin
      if (it.func >= CMD_START && it.func <= CMD_ACK) begin
        cmd_q = it.func;
        nbits = '0;
        case (it.func)
          CMD_START: enter_step(PH_S_SDAHI);
          CMD_STOP: enter_step(PH_P_SDALO);
          CMD_WRITE: begin
            shreg = it.tx_byte;
            enter_step(PH_B_SET);
          end
          CMD_READ: begin
            shreg = '0;
            enter_step(PH_R_LOW);
          end
          default: begin
            // ack bit goes out as the msb of a one-bit write
            shreg = {it.ack_bit, 7'd0};
            enter_step(PH_B_SET);
          end
        endcase
      end
    end else if (hold_left != 16'd0) begin
      hold_left = hold_left - 16'd1;
    end else begin
      case (step_q)
        PH_S_SDAHI: enter_step(PH_S_SCLHI);
        PH_S_SCLHI: enter_step(PH_S_SDALO);
        PH_S_SDALO: enter_step(PH_S_SCLLO);
        PH_P_SDALO: enter_step(PH_P_SCLHI);
        PH_P_SCLHI: enter_step(PH_P_SDAHI);
        PH_B_SET: enter_step(PH_B_HIGH);
        PH_B_HIGH: enter_step(PH_B_LOW);
        PH_B_LOW: begin
          if (cmd_q == CMD_ACK) begin
            fin = 1'b1;
          end else begin
            shreg = shreg << 1;
            nbits = nbits + 4'd1;
            enter_step((nbits < BITS_PER_BYTE) ? PH_B_SET : PH_A_REL);
          end
        end
        PH_A_REL: enter_step(PH_A_HIGH);
        PH_A_HIGH: begin
          ack_q = !it.sda_in;
          enter_step(PH_END_LOW);
        end
        PH_END_LOW: begin
          if (cmd_q == CMD_READ) rx_q = shreg;
          fin = 1'b1;
        end
        PH_R_LOW: enter_step(PH_R_HIGH);
        PH_R_HIGH: begin
          shreg = {shreg[6:0], it.sda_in};
          nbits = nbits + 4'd1;
          enter_step((nbits < BITS_PER_BYTE) ? PH_R_LOW : PH_END_LOW);
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        step_q = PH_IDLE;
        hold_left = '0;
      end
    end
    r.scl = scl_q;
    r.sda_out = sda_q;
    r.busy_res = (step_q != PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rx_q;
    r.ack_seen = ack_q;
    return r;
  endfunction

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic line_level(sda_mode_t mode);
    case (mode)
      SDA_LOW: return 1'b0;
      SDA_HIGH: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic void add_item(logic [2:0] f, logic [7:0] tx, logic ab, logic sda);
    in_item_t it;
    it.func = f;
    it.tx_byte = tx;
    it.ack_bit = ab;
    it.sda_in = sda;
    tick_items.push_back(it);
    items_queued++;
  endfunction

  // one command followed by the ticks that carry it to completion; noise_pct
  // of the busy ticks carry a command that the engine must ignore
  function automatic void queue_cmd(logic [2:0] f, logic [7:0] tx, logic ab,
                                    sda_mode_t mode, int noise_pct);
    int         steps;
    int         len;
    logic [2:0] idle_f;
    case (f)
      CMD_START: steps = 4;
      CMD_STOP: steps = 3;
      CMD_WRITE: steps = 3 * BITS_PER_BYTE + 3;
      CMD_READ: steps = 2 * BITS_PER_BYTE + 1;
      CMD_ACK: steps = 3;
      default: steps = 0;
    endcase
    len = (tick_len == 16'd0) ? 1 : int'(tick_len);
    add_item(f, tx, ab, line_level(mode));
    for (int k = 0; k < steps * len; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        add_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                 line_level(mode));
      else
        add_item(CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)), line_level(mode));
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 2))
          0: idle_f = CMD_NONE;
          1: idle_f = FUNC_RSVD_A;
          default: idle_f = FUNC_RSVD_B;
        endcase
        add_item(idle_f, 8'($urandom), 1'($urandom_range(0, 1)), line_level(mode));
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || line_expect.size() != 0);
  endtask

  task automatic apb_xfer(bit wr, logic [31:0] wd, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_PHASE_TICKS, 2'b00};
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_ticks(logic [15:0] v);
    logic [31:0] rd;
    logic [31:0] junk;
    wait_drained();
    // let the engine finish its command before touching the register
    while (step_q != PH_IDLE) begin
      add_item(CMD_NONE, '0, 1'b0, 1'b1);
      wait_drained();
    end
    repeat (2) @(negedge clk);
    junk = $urandom;
    apb_xfer(1'b1, {junk[15:0], v}, rd);
    tick_len = v;
    apb_xfer(1'b0, '0, rd);
    if (rd[15:0] !== v) begin
      if (errors < 10) $display("phase_ticks readback: expected %04h got %04h", v, rd[15:0]);
      errors++;
    end
  endtask

  // input side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (tick_items.size() != 0) begin
        in_data <= tick_items.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_taken) out_hold = pick_wait();
      if (out_hold != 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : mon
    out_item_t want;
    out_item_t got;
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if ($urandom_range(0, 63) == 0) calm <= !calm;
    if (rst_n && in_valid && in_ready) begin
      line_expect.push_back(bus_tick(in_data));
      items_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (line_expect.size() == 0) begin
        if (errors < 10) $display("result with nothing pending: %p", got);
        errors++;
      end else begin
        want = line_expect.pop_front();
        if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen) begin
          if (errors < 10) begin
            $display("mismatch: expected scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                     want.scl, want.sda_out, want.busy_res, want.done_res,
                     want.rx_byte, want.ack_seen);
            $display("          actual   scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                     got.scl, got.sda_out, got.busy_res, got.done_res,
                     got.rx_byte, got.ack_seen);
          end
          errors++;
        end
      end
    end
  end

  initial begin : stim
    int cfgs[3];
    int goal;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset phase length
    queue_cmd(CMD_START, 8'($urandom), 1'b0, SDA_RAND, 0);
    queue_cmd(CMD_STOP, 8'($urandom), 1'b1, SDA_RAND, 0);

    set_ticks(16'd1);
    queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
    queue_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
    queue_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
    // a command on every busy tick, the completion tick included
    queue_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 100);
    queue_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
    queue_cmd(CMD_ACK, 8'hFF, 1'b0, SDA_RAND, 0);
    queue_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
    queue_cmd(CMD_ACK, 8'h00, 1'b1, SDA_RAND, 0);
    queue_cmd(CMD_READ, 8'($urandom), 1'b0, SDA_RAND, 0);
    add_item(FUNC_RSVD_A, 8'($urandom), 1'b1, 1'b0);
    add_item(FUNC_RSVD_B, 8'($urandom), 1'b0, 1'b1);
    add_item(CMD_NONE, 8'($urandom), 1'b1, 1'b1);
    // repeated start, then stop twice in a row
    queue_cmd(CMD_START, 8'($urandom), 1'b1, SDA_RAND, 0);
    queue_cmd(CMD_STOP, 8'($urandom), 1'b0, SDA_RAND, 0);
    queue_cmd(CMD_STOP, 8'($urandom), 1'b1, SDA_RAND, 0);
    queue_cmd(CMD_ACK, 8'($urandom), 1'b1, SDA_RAND, 0);

    cfgs = '{0, 2, 3};
    cfgs[2] = $urandom_range(2, 3);
    for (int p = 0; p < 3; p++) begin
      set_ticks(16'(cfgs[p]));
      goal = items_queued + 20;
      while (items_queued < goal) begin
        if ($urandom_range(0, 4) != 0) begin
          // address byte, at most one data byte, then stop
          queue_cmd(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
          queue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
          repeat ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) begin
              queue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
            end else begin
              queue_cmd(CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
              queue_cmd(CMD_ACK, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
            end
          end
          queue_cmd(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 10);
        end else begin
          queue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                    SDA_RAND, 40);
        end
      end
    end

    // longest phase: only the first step of a start fits in the run
    set_ticks(16'hFFFF);
    add_item(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (15)
      add_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2c_master_byte_engine.sv
tb/testbench.sv
